// ----- src/euler_1d_force_flux_top_macros.svh -----
// Assertion macros for the flux block RTL.
// Included by eu1d_ctrl, the module that checks its own control logic.
`ifndef EULER_1D_FORCE_FLUX_TOP_MACROS_SVH
`define EULER_1D_FORCE_FLUX_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define EU1D_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define EU1D_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/eu1d_pkg.sv -----
// Types, constants and the operation program of the FORCE flux block.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package eu1d_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;

    localparam int GAMMA_BITS = 18;
    localparam int RATIO_BITS = 32;
    localparam int CFG_BITS   = 32;
    localparam int CFG_IDX_BITS = 2;
    localparam int IO_BITS    = 32;

    localparam logic [CFG_IDX_BITS-1:0] CFG_GAMMA = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HDX   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HXD   = 2'd2;

    localparam logic [GAMMA_BITS-1:0] GAMMA_RST = 18'd26214;
    localparam logic [RATIO_BITS-1:0] HDX_RST   = 32'd32768;
    localparam logic [RATIO_BITS-1:0] HXD_RST   = 32'd32768;

    typedef logic [4:0] t_slot;
    typedef logic [5:0] t_pc;

    // Operand slots. The six cell slots live in registers, the rest in a scratch RAM,
    // and the three output slots go to the result registers.
    localparam t_slot SL_QL0 = 5'd0;
    localparam t_slot SL_QR0 = 5'd3;
    localparam t_slot SL_FL0 = 5'd6;
    localparam t_slot SL_FR0 = 5'd9;
    localparam t_slot SL_QH0 = 5'd12;
    localparam t_slot SL_FH0 = 5'd15;
    localparam t_slot SL_U   = 5'd18;
    localparam t_slot SL_RUU = 5'd19;
    localparam t_slot SL_T   = 5'd20;
    localparam t_slot SL_P   = 5'd21;
    localparam t_slot SL_T2  = 5'd22;
    localparam t_slot SL_OUT0 = 5'd23;

    localparam t_pc PC_LAST = 6'd62;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_HALF,
        OP_MULG,
        OP_MULHDX,
        OP_MULHXD,
        OP_DIV
    } t_op;

    typedef struct packed {
        t_op   op;
        t_slot dst;
        t_slot a;
        t_slot b;
    } t_uop;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_WAIT,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic rd;
        logic wr;
        logic emit;
        t_pc  pc;
    } t_dp_cmd;

    typedef struct packed {
        logic done;
        logic out_free;
    } t_dp_sts;

    function automatic t_uop mk_uop(input t_op op, input t_slot d, input t_slot a,
                                    input t_slot b);
        t_uop u;
        u.op  = op;
        u.dst = d;
        u.a   = a;
        u.b   = b;
        return u;
    endfunction

    // The program: flux of the left cell, flux of the right cell, half-step state,
    // flux of the half-step state, then the three FORCE outputs.
    function automatic t_uop prog_uop(input t_pc pc);
        t_uop  u;
        t_slot s;
        t_slot f;
        t_pc   k;
        t_pc   j;
        t_slot i;
        u = mk_uop(OP_ADD, SL_T, SL_T, SL_T);
        s = SL_QL0;
        f = SL_FL0;
        k = 6'd0;
        j = 6'd0;
        i = 5'd0;
        if (pc < 6'd18 || (pc >= 6'd33 && pc < 6'd42)) begin
            if (pc < 6'd9) begin
                k = pc;
            end else if (pc < 6'd18) begin
                k = pc - 6'd9;
                s = SL_QR0;
                f = SL_FR0;
            end else begin
                k = pc - 6'd33;
                s = SL_QH0;
                f = SL_FH0;
            end
            case (k)
                6'd0: u = mk_uop(OP_DIV, SL_U, s + 5'd1, s);
                6'd1: u = mk_uop(OP_MUL, f, s, SL_U);
                6'd2: u = mk_uop(OP_MUL, SL_RUU, f, SL_U);
                6'd3: u = mk_uop(OP_HALF, SL_T, SL_RUU, SL_RUU);
                6'd4: u = mk_uop(OP_SUB, SL_T, s + 5'd2, SL_T);
                6'd5: u = mk_uop(OP_MULG, SL_P, SL_T, SL_T);
                6'd6: u = mk_uop(OP_ADD, f + 5'd1, SL_RUU, SL_P);
                6'd7: u = mk_uop(OP_ADD, SL_T, s + 5'd2, SL_P);
                default: u = mk_uop(OP_MUL, f + 5'd2, SL_T, SL_U);
            endcase
        end else if (pc < 6'd33) begin
            j = pc - 6'd18;
            i = (j < 6'd5) ? 5'd0 : ((j < 6'd10) ? 5'd1 : 5'd2);
            k = j - 6'(i) * 6'd5;
            case (k)
                6'd0: u = mk_uop(OP_ADD, SL_T, SL_QL0 + i, SL_QR0 + i);
                6'd1: u = mk_uop(OP_HALF, SL_T, SL_T, SL_T);
                6'd2: u = mk_uop(OP_SUB, SL_T2, SL_FL0 + i, SL_FR0 + i);
                6'd3: u = mk_uop(OP_MULHDX, SL_T2, SL_T2, SL_T2);
                default: u = mk_uop(OP_ADD, SL_QH0 + i, SL_T, SL_T2);
            endcase
        end else begin
            j = pc - 6'd42;
            i = (j < 6'd7) ? 5'd0 : ((j < 6'd14) ? 5'd1 : 5'd2);
            k = j - 6'(i) * 6'd7;
            case (k)
                6'd0: u = mk_uop(OP_ADD, SL_T, SL_FL0 + i, SL_FR0 + i);
                6'd1: u = mk_uop(OP_HALF, SL_T, SL_T, SL_T);
                6'd2: u = mk_uop(OP_SUB, SL_T2, SL_QL0 + i, SL_QR0 + i);
                6'd3: u = mk_uop(OP_MULHXD, SL_T2, SL_T2, SL_T2);
                6'd4: u = mk_uop(OP_ADD, SL_T, SL_T, SL_T2);
                6'd5: u = mk_uop(OP_ADD, SL_T, SL_T, SL_FH0 + i);
                default: u = mk_uop(OP_HALF, SL_OUT0 + i, SL_T, SL_T);
            endcase
        end
        return u;
    endfunction

endpackage

// ----- src/eu1d_ctrl.sv -----
// Sequencer of the FORCE flux block: accepts cells and steps the datapath
// through the operation program. Depends on eu1d_pkg and the assertion macros.
`timescale 1ns / 1ps
`include "euler_1d_force_flux_top_macros.svh"

module eu1d_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_first_of_sweep,
    output logic               o_in_stall,
    output eu1d_pkg::t_dp_cmd  o_cmd,
    input  eu1d_pkg::t_dp_sts  i_sts
);
    import eu1d_pkg::*;

    t_state r_state;
    t_state n_state;
    t_pc    r_pc;
    t_pc    n_pc;
    logic   r_have_prev;
    logic   accept;
    logic   starts;

    assign accept = i_in_valid && (r_state == S_IDLE);
    assign starts = i_first_of_sweep || !r_have_prev;

    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        case (r_state)
            S_IDLE: begin
                if (accept && !starts) begin
                    n_state = S_READ;
                    n_pc    = '0;
                end
            end
            S_READ: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (i_sts.done) begin
                    if (r_pc == PC_LAST) begin
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_READ;
                        n_pc    = r_pc + 6'd1;
                    end
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.pc   = r_pc;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = accept;
            end
            S_READ: o_cmd.rd = 1'b1;
            S_WAIT: o_cmd.wr = i_sts.done;
            S_EMIT: o_cmd.emit = i_sts.out_free;
            default: o_in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= '0;
            r_have_prev <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            if (accept) begin
                r_have_prev <= 1'b1;
            end
        end
    end

    `EU1D_ASSERT_NOW(a_done_in_wait, i_clk, i_rst_n, i_sts.done, r_state == S_WAIT, "unit result outside wait")
    `EU1D_ASSERT_NEXT(a_start_no_result, i_clk, i_rst_n, accept && starts, r_state == S_IDLE, "first cell started work")
    `EU1D_ASSERT_NOW(a_pc_range, i_clk, i_rst_n, r_state != S_IDLE, r_pc <= PC_LAST, "program counter past end")

endmodule

// ----- src/eu1d_dp.sv -----
// Datapath of the FORCE flux block: cell registers, scratch RAM, shared
// add, multiply and divide units, and the result register. Depends on eu1d_pkg.
`timescale 1ns / 1ps

module eu1d_dp #(
    parameter int WORD_BITS = eu1d_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = eu1d_pkg::FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [eu1d_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  logic [eu1d_pkg::CFG_BITS-1:0]         i_cfg_data,
    input  logic signed [eu1d_pkg::IO_BITS-1:0]   i_density,
    input  logic signed [eu1d_pkg::IO_BITS-1:0]   i_momentum,
    input  logic signed [eu1d_pkg::IO_BITS-1:0]   i_energy,
    input  eu1d_pkg::t_dp_cmd                     i_cmd,
    output eu1d_pkg::t_dp_sts                     o_sts,
    input  logic                                  i_out_stall,
    output logic                                  o_out_valid,
    output logic signed [eu1d_pkg::IO_BITS-1:0]   o_mass_flux,
    output logic signed [eu1d_pkg::IO_BITS-1:0]   o_momentum_flux,
    output logic signed [eu1d_pkg::IO_BITS-1:0]   o_energy_flux,
    output logic                                  o_fault
);
    import eu1d_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int OW = (W > RATIO_BITS) ? W : RATIO_BITS;
    localparam int H  = (OW + 1) / 2;
    localparam int AW = 4 * H;
    localparam int DW = W + F;
    localparam int MW = (AW > DW) ? AW : DW;
    localparam int CW = $clog2(DW);

    localparam logic [W-1:0]  WMAX_W = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  WMIN_W = ~WMAX_W;
    localparam logic [OW-1:0] WMAX_X = {{(OW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic [OW-1:0] WMIN_X = ~WMAX_X;
    localparam logic [MW-1:0] LIM_M  = {{(MW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic [OW-1:0] HALF_X = {{(OW-1){1'b0}}, 1'b1} << (F - 1);

    // Configuration
    logic [GAMMA_BITS-1:0] r_gamma;
    logic [RATIO_BITS-1:0] r_hdx;
    logic [RATIO_BITS-1:0] r_hxd;

    // Cell registers and scratch
    logic [W-1:0] r_ql [0:2];
    logic [W-1:0] r_qr [0:2];
    logic [W-1:0] r_mem [0:31];
    logic [W-1:0] r_fin [0:2];

    logic [W-1:0] r_opa;
    logic [W-1:0] r_opb;
    t_op          r_op;
    t_slot        r_dst;
    logic         r_go;

    logic [W-1:0] r_res;
    logic         r_sat;
    logic         r_done;
    logic         r_fault;

    // Multiplier
    logic          r_mul_busy;
    logic [1:0]    r_mul_k;
    logic [2*H-1:0] r_ma;
    logic [2*H-1:0] r_mb;
    logic [AW-1:0] r_acc;
    logic          r_neg;

    // Divider
    logic          r_div_busy;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_num;
    logic [DW-1:0] r_quo;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_dvs;

    // Shared saturating finish
    logic          r_fin_go;
    logic [MW-1:0] r_fin_mag;

    logic [W:0]    load_d;
    logic [W:0]    load_m;
    logic [W:0]    load_e;
    t_uop          uop;
    logic [W-1:0]  cell_a;
    logic [W-1:0]  cell_b;
    logic [W:0]    sum_x;
    logic [W-1:0]  sum_w;
    logic          sum_ovf;
    logic          a_neg;
    logic          b_neg;
    logic [W-1:0]  mag_a;
    logic [W-1:0]  mag_b;
    logic [OW-1:0] mul_b;
    logic          mul_bneg;
    logic [H-1:0]  pa;
    logic [H-1:0]  pb;
    logic [2*H-1:0] pp;
    logic [AW-1:0] pp_sh;
    logic [AW-1:0] acc_next;
    logic [1:0]    pp_pos;
    logic [W:0]    trial;
    logic          take;
    logic [DW-1:0] quo_next;
    logic [W-1:0]  rem_next;
    logic          fin_sat;
    logic [W-1:0]  fin_word;
    logic [MW-1:0] fin_lim;
    t_slot         oi;

    function automatic logic [W:0] load_word(input logic signed [IO_BITS-1:0] v);
        logic signed [OW-1:0] x;
        x = OW'(v);
        if (x > $signed(WMAX_X)) begin
            return {1'b1, WMAX_W};
        end else if (x < $signed(WMIN_X)) begin
            return {1'b1, WMIN_W};
        end
        return {1'b0, x[W-1:0]};
    endfunction

    function automatic logic [W-1:0] cell_rd(input t_slot s, input logic [W-1:0] q0,
                                              input logic [W-1:0] q1, input logic [W-1:0] q2,
                                              input logic [W-1:0] q3, input logic [W-1:0] q4,
                                              input logic [W-1:0] q5);
        case (s)
            5'd0: return q0;
            5'd1: return q1;
            5'd2: return q2;
            5'd3: return q3;
            5'd4: return q4;
            default: return q5;
        endcase
    endfunction

    function automatic logic [IO_BITS-1:0] low_out(input logic [W-1:0] w);
        logic signed [OW-1:0] e;
        e = OW'($signed(w));
        return e[IO_BITS-1:0];
    endfunction

    assign load_d = load_word(i_density);
    assign load_m = load_word(i_momentum);
    assign load_e = load_word(i_energy);

    assign uop    = prog_uop(i_cmd.pc);
    assign cell_a = cell_rd(uop.a, r_ql[0], r_ql[1], r_ql[2], r_qr[0], r_qr[1], r_qr[2]);
    assign cell_b = cell_rd(uop.b, r_ql[0], r_ql[1], r_ql[2], r_qr[0], r_qr[1], r_qr[2]);

    // Saturating add and subtract
    always_comb begin
        if (r_op == OP_SUB) begin
            sum_x = {r_opa[W-1], r_opa} - {r_opb[W-1], r_opb};
        end else begin
            sum_x = {r_opa[W-1], r_opa} + {r_opb[W-1], r_opb};
        end
        sum_ovf = sum_x[W] != sum_x[W-1];
        sum_w   = sum_ovf ? (sum_x[W] ? WMIN_W : WMAX_W) : sum_x[W-1:0];
    end

    assign a_neg = r_opa[W-1];
    assign b_neg = r_opb[W-1];
    assign mag_a = a_neg ? (~r_opa + 1'b1) : r_opa;
    assign mag_b = b_neg ? (~r_opb + 1'b1) : r_opb;

    always_comb begin
        mul_bneg = 1'b0;
        case (r_op)
            OP_MUL: begin
                mul_b    = OW'(mag_b);
                mul_bneg = b_neg;
            end
            OP_HALF:   mul_b = HALF_X;
            OP_MULG:   mul_b = OW'(r_gamma);
            OP_MULHDX: mul_b = OW'(r_hdx);
            OP_MULHXD: mul_b = OW'(r_hxd);
            default:   mul_b = HALF_X;
        endcase
    end

    // One H by H partial product a cycle.
    always_comb begin
        pa     = r_mul_k[1] ? r_ma[2*H-1:H] : r_ma[H-1:0];
        pb     = r_mul_k[0] ? r_mb[2*H-1:H] : r_mb[H-1:0];
        pp     = pa * pb;
        pp_pos = {1'b0, r_mul_k[1]} + {1'b0, r_mul_k[0]};
        case (pp_pos)
            2'd0: pp_sh = AW'(pp);
            2'd1: pp_sh = AW'(pp) << H;
            default: pp_sh = AW'(pp) << (2 * H);
        endcase
        acc_next = r_acc + pp_sh;
    end

    // One quotient bit a cycle, restoring.
    always_comb begin
        trial    = {r_rem, r_num[DW-1]};
        take     = trial >= {1'b0, r_dvs};
        rem_next = take ? W'(trial - {1'b0, r_dvs}) : trial[W-1:0];
        quo_next = {r_quo[DW-2:0], take};
    end

    always_comb begin
        fin_lim  = LIM_M + MW'(r_neg);
        fin_sat  = r_fin_mag > fin_lim;
        if (fin_sat) begin
            fin_word = r_neg ? WMIN_W : WMAX_W;
        end else if (r_neg) begin
            fin_word = ~r_fin_mag[W-1:0] + 1'b1;
        end else begin
            fin_word = r_fin_mag[W-1:0];
        end
    end

    assign oi = r_dst - SL_OUT0;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gamma     <= GAMMA_RST;
            r_hdx       <= HDX_RST;
            r_hxd       <= HXD_RST;
            r_go        <= 1'b0;
            r_done      <= 1'b0;
            r_mul_busy  <= 1'b0;
            r_div_busy  <= 1'b0;
            r_fin_go    <= 1'b0;
            r_fault     <= 1'b0;
            o_out_valid <= 1'b0;
            for (int n = 0; n < 3; n++) begin
                r_ql[n] <= '0;
                r_qr[n] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_GAMMA: r_gamma <= i_cfg_data[GAMMA_BITS-1:0];
                    CFG_HDX:   r_hdx   <= i_cfg_data[RATIO_BITS-1:0];
                    CFG_HXD:   r_hxd   <= i_cfg_data[RATIO_BITS-1:0];
                    default:   r_gamma <= r_gamma;
                endcase
            end
            r_go     <= i_cmd.rd;
            r_done   <= 1'b0;
            r_fin_go <= 1'b0;
            if (i_cmd.load) begin
                r_ql[0] <= r_qr[0];
                r_ql[1] <= r_qr[1];
                r_ql[2] <= r_qr[2];
                r_qr[0] <= load_d[W-1:0];
                r_qr[1] <= load_m[W-1:0];
                r_qr[2] <= load_e[W-1:0];
                r_fault <= load_d[W] | load_m[W] | load_e[W];
            end else if (r_done) begin
                r_fault <= r_fault | r_sat;
            end
            if (r_go) begin
                case (r_op)
                    OP_ADD, OP_SUB: r_done <= 1'b1;
                    OP_DIV: begin
                        if (b_neg || r_opb == '0) begin
                            r_done <= 1'b1;
                        end else begin
                            r_div_busy <= 1'b1;
                        end
                    end
                    default: r_mul_busy <= 1'b1;
                endcase
            end
            if (r_mul_busy && r_mul_k == 2'd3) begin
                r_mul_busy <= 1'b0;
                r_fin_go   <= 1'b1;
            end
            if (r_div_busy && r_cnt == '0) begin
                r_div_busy <= 1'b0;
                r_fin_go   <= 1'b1;
            end
            if (r_fin_go) begin
                r_done <= 1'b1;
            end
            if (i_cmd.emit) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_op  <= uop.op;
            r_dst <= uop.dst;
            r_opa <= (uop.a < SL_FL0) ? cell_a : r_mem[uop.a];
            r_opb <= (uop.b < SL_FL0) ? cell_b : r_mem[uop.b];
        end
        if (i_cmd.wr) begin
            if (r_dst >= SL_OUT0) begin
                r_fin[oi[1:0]] <= r_res;
            end else begin
                r_mem[r_dst] <= r_res;
            end
        end
        if (r_go) begin
            case (r_op)
                OP_ADD, OP_SUB: begin
                    r_res <= sum_w;
                    r_sat <= sum_ovf;
                end
                OP_DIV: begin
                    r_neg <= a_neg;
                    r_num <= {mag_a, {F{1'b0}}};
                    r_dvs <= r_opb;
                    r_rem <= '0;
                    r_quo <= '0;
                    r_cnt <= CW'(DW - 1);
                    r_sat <= 1'b1;
                    if (a_neg) begin
                        r_res <= WMIN_W;
                    end else if (r_opa != '0) begin
                        r_res <= WMAX_W;
                    end else begin
                        r_res <= '0;
                    end
                end
                default: begin
                    r_neg   <= a_neg ^ mul_bneg;
                    r_ma    <= (2*H)'(mag_a);
                    r_mb    <= (2*H)'(mul_b);
                    r_acc   <= '0;
                    r_mul_k <= 2'd0;
                end
            endcase
        end
        if (r_mul_busy) begin
            r_acc     <= acc_next;
            r_mul_k   <= r_mul_k + 2'd1;
            r_fin_mag <= MW'(acc_next >> F);
        end
        if (r_div_busy) begin
            r_num     <= r_num << 1;
            r_rem     <= rem_next;
            r_quo     <= quo_next;
            r_cnt     <= r_cnt - 1'b1;
            r_fin_mag <= MW'(quo_next);
        end
        if (r_fin_go) begin
            r_res <= fin_word;
            r_sat <= fin_sat;
        end
        if (i_cmd.emit) begin
            o_mass_flux     <= low_out(r_fin[0]);
            o_momentum_flux <= low_out(r_fin[1]);
            o_energy_flux   <= low_out(r_fin[2]);
            o_fault         <= r_fault;
        end
    end

    assign o_sts.done     = r_done;
    assign o_sts.out_free = !o_out_valid || !i_out_stall;

endmodule

// ----- src/euler_1d_force_flux_top.sv -----
// FORCE interface flux for the 1D Euler equations, one cell per input beat.
// Input beats carry a cell state; output beats carry the flux across the
// interface to the previous cell. Cells marked first of sweep, and the first
// cell after reset, are stored and give no output beat.
// Both channels use valid/stall; a beat moves when valid is high and stall low.
// Configuration registers (gamma-1, dt/dx/2, dx/dt/2) are written through a plain write port;
// the user must write them only while the block is idle, the block itself does not enforce this.
// Each interface runs a 63-step program on shared units: add, multiply (four
// partial products) and divide. A new cell is taken only once the program has
// finished and the result has moved into the output register; stored-only
// cells are taken in the idle state and start no program.
// A stalled output beat holds; the next cell can be accepted and computed
// meanwhile, and its result waits for the output register to free.
// Reset is synchronous and active low; it clears the stored cell to zero and
// restores the register defaults.
`timescale 1ns / 1ps

module euler_1d_force_flux_top #(
    parameter int WORD_BITS = eu1d_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = eu1d_pkg::FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [eu1d_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  logic [eu1d_pkg::CFG_BITS-1:0]         i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [eu1d_pkg::IO_BITS-1:0]   i_density,
    input  logic signed [eu1d_pkg::IO_BITS-1:0]   i_momentum,
    input  logic signed [eu1d_pkg::IO_BITS-1:0]   i_energy,
    input  logic                                  i_first_of_sweep,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [eu1d_pkg::IO_BITS-1:0]   o_mass_flux,
    output logic signed [eu1d_pkg::IO_BITS-1:0]   o_momentum_flux,
    output logic signed [eu1d_pkg::IO_BITS-1:0]   o_energy_flux,
    output logic                                  o_fault
);
    import eu1d_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    eu1d_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_first_of_sweep (i_first_of_sweep),
        .o_in_stall       (o_in_stall),
        .o_cmd            (cmd),
        .i_sts            (sts)
    );

    eu1d_dp #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_density       (i_density),
        .i_momentum      (i_momentum),
        .i_energy        (i_energy),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_mass_flux     (o_mass_flux),
        .o_momentum_flux (o_momentum_flux),
        .o_energy_flux   (o_energy_flux),
        .o_fault         (o_fault)
    );

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the FORCE flux block: drives cell beats, predicts
// each interface flux in fixed point and compares every output beat in order.
// Depends on eu1d_pkg and euler_1d_force_flux_top.
`timescale 1ns / 1ps

module tb_top;
    import eu1d_pkg::*;

    localparam longint WMAX = 64'sh7FFF_FFFF;
    localparam longint WMIN = -64'sh8000_0000;
    localparam int HOLD_CYCLES = 1500;
    localparam int DRAIN_CYCLES = 600;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic [31:0] mass;
        logic [31:0] mom;
        logic [31:0] nrg;
        logic        fault;
    } t_flux;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx;
    logic [CFG_BITS-1:0]     i_cfg_data;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic signed [31:0]      i_density;
    logic signed [31:0]      i_momentum;
    logic signed [31:0]      i_energy;
    logic                    i_first_of_sweep;
    logic                    o_out_valid;
    logic                    i_out_stall;
    logic signed [31:0]      o_mass_flux;
    logic signed [31:0]      o_momentum_flux;
    logic signed [31:0]      o_energy_flux;
    logic                    o_fault;

    euler_1d_force_flux_top dut (.*);

    // Predictor state and configuration.
    longint gamma_m1;
    longint hdt_dx;
    longint hdx_dt;
    longint left_cell [3];
    bit     have_left;
    bit     sat_seen;

    t_flux  flux_queue [$];
    int     mismatches;
    bit     idle_on;
    bit     hold_req;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Fixed-point helpers: every step saturates to the word and flags it.
    function automatic longint to_word(bit neg, logic [127:0] mag);
        logic [127:0] limit;
        limit = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (mag > limit) begin
            sat_seen = 1'b1;
            return neg ? WMIN : WMAX;
        end
        return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
    endfunction

    function automatic longint clamp(longint v);
        if (v > WMAX) begin
            sat_seen = 1'b1;
            return WMAX;
        end
        if (v < WMIN) begin
            sat_seen = 1'b1;
            return WMIN;
        end
        return v;
    endfunction

    function automatic logic [127:0] mag_of(longint a);
        logic [127:0] m;
        m = (a < 0) ? 128'(-a) : 128'(a);
        return m;
    endfunction

    function automatic longint q_mul(longint a, longint b);
        logic [127:0] p;
        p = (mag_of(a) * mag_of(b)) >> 16;
        return to_word((a < 0) != (b < 0), p);
    endfunction

    function automatic longint q_half(longint a);
        return q_mul(a, 64'sd32768);
    endfunction

    function automatic longint q_div(longint a, longint b);
        logic [127:0] q;
        if (b <= 0) begin
            sat_seen = 1'b1;
            return (a > 0) ? WMAX : ((a < 0) ? WMIN : 64'sd0);
        end
        q = (mag_of(a) << 16) / 128'(b);
        return to_word(a < 0, q);
    endfunction

    task automatic gas_flux(input longint s [3], output longint f [3]);
        longint u, ru, ruu, p;
        u = q_div(s[1], s[0]);
        ru = q_mul(s[0], u);
        ruu = q_mul(ru, u);
        p = q_mul(gamma_m1, clamp(s[2] - q_half(ruu)));
        f[0] = ru;
        f[1] = clamp(ruu + p);
        f[2] = q_mul(clamp(s[2] + p), u);
    endtask

    // Updates the stored cell and queues the flux this cell produces, if any.
    task automatic predict_force_flux(input logic [31:0] d, m, e, input bit first);
        longint ql [3], qr [3], fl [3], fr [3], qh [3], fh [3], lf, o [3];
        t_flux  r;
        sat_seen = 1'b0;
        qr[0] = longint'($signed(d));
        qr[1] = longint'($signed(m));
        qr[2] = longint'($signed(e));
        ql = left_cell;
        left_cell = qr;
        if (first || !have_left) begin
            have_left = 1'b1;
            return;
        end
        gas_flux(ql, fl);
        gas_flux(qr, fr);
        for (int i = 0; i < 3; i++)
            qh[i] = clamp(q_half(clamp(ql[i] + qr[i])) +
                          q_mul(hdt_dx, clamp(fl[i] - fr[i])));
        gas_flux(qh, fh);
        for (int i = 0; i < 3; i++) begin
            lf = clamp(q_half(clamp(fl[i] + fr[i])) + q_mul(hdx_dt, clamp(ql[i] - qr[i])));
            o[i] = q_half(clamp(lf + fh[i]));
        end
        r.mass = o[0][31:0];
        r.mom = o[1][31:0];
        r.nrg = o[2][31:0];
        r.fault = sat_seen;
        flux_queue = {flux_queue, r};
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got, exp_v);
        $display("mismatch %s: got %h, want %h at %0t", what, got, exp_v, $realtime);
        mismatches++;
    endtask

    // Sends one cell beat, with an occasional idle burst before it.
    task automatic send_cell(input logic [31:0] d, m, e, input bit first);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_density <= d;
        i_momentum <= m;
        i_energy <= e;
        i_first_of_sweep <= first;
        do @(posedge i_clk); while (o_in_stall);
        predict_force_flux(d, m, e, first);
    endtask

    task automatic end_input;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_idle;
        i_in_valid <= 1'b0;
        while (flux_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_GAMMA: gamma_m1 = longint'(val[GAMMA_BITS-1:0]);
            CFG_HDX:   hdt_dx = longint'(val);
            CFG_HXD:   hdx_dt = longint'(val);
            default: ;
        endcase
    endtask

    // A plausible gas cell most of the time, raw noise otherwise.
    task automatic send_random_cell(input bit sweep_start);
        logic [31:0] d, m, e;
        if ($urandom_range(0, 9) == 0) begin
            d = $urandom;
            m = $urandom;
            e = $urandom;
        end else begin
            d = $urandom_range(32'h0000_1000, 32'h000A_0000);
            m = $urandom_range(0, d * 2);
            if ($urandom_range(0, 1)) m = -m;
            e = $urandom_range(32'h0001_0000, 32'h0028_0000);
        end
        send_cell(d, m, e, sweep_start || $urandom_range(0, 15) == 0);
    endtask

    task automatic test_directed;
        send_cell(32'h0001_0000, 32'h0000_8000, 32'h0002_0000, 1'b0);
        send_cell(32'h0000_8000, 32'hFFFF_C000, 32'h0001_0000, 1'b0);
        send_cell(32'h0000_0000, 32'h0001_0000, 32'h0001_0000, 1'b0);
        send_cell(32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 1'b0);
        send_cell(32'hFFFF_0000, 32'hFFFF_0000, 32'h0001_0000, 1'b0);
        send_cell(32'h0001_0000, 32'h0000_0000, 32'h0001_0000, 1'b0);
        send_cell(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_cell(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
        send_cell(32'h0000_0001, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0);
        send_cell(32'h0002_0000, 32'h0000_0001, 32'hFFFF_0000, 1'b1);
        send_cell(32'h0001_8000, 32'hFFFE_0000, 32'h0003_0000, 1'b0);
        send_cell(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 1'b0);
        send_cell(32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 1'b1);
        send_cell(32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 1'b1);
        send_cell(32'h0010_0000, 32'h0040_0000, 32'h0100_0000, 1'b0);
        send_cell(32'h0000_4000, 32'hFFC0_0000, 32'h0000_2000, 1'b0);
        wait_idle();
    endtask

    task automatic test_config_settings;
        logic [31:0] g [3], a [3], b [3];
        g = '{32'd0, 32'd131072, 32'd45875};
        a = '{32'd0, 32'hFFFF_FFFF, 32'h0000_2000};
        b = '{32'd0, 32'hFFFF_FFFF, 32'h0002_0000};
        for (int k = 0; k < 3; k++) begin
            cfg_write(CFG_GAMMA, g[k]);
            cfg_write(CFG_HDX, a[k]);
            cfg_write(CFG_HXD, b[k]);
            for (int n = 0; n < 60; n++) send_random_cell(n == 0);
            wait_idle();
        end
        cfg_write(CFG_GAMMA, 32'd26214);
        cfg_write(CFG_HDX, 32'd32768);
        cfg_write(CFG_HXD, 32'd32768);
    endtask

    // The receiver holds off while cells keep coming, so the block backs up.
    task automatic test_backpressure;
        hold_req = 1'b1;
        for (int n = 0; n < 30; n++) send_random_cell(n == 0);
    endtask

    task automatic test_random;
        for (int n = 0; n < 550; n++) send_random_cell(1'b0);
        idle_on = 1'b0;
        for (int n = 0; n < 100; n++) send_random_cell(1'b0);
        end_input();
    endtask

    // Output side: checks each beat and drives the stall pattern.
    int stall_left;
    int hold_left;
    always @(posedge i_clk) begin
        t_flux w;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (flux_queue.size() == 0) begin
                    report_mismatch("unexpected beat", o_mass_flux, 32'd0);
                end else begin
                    w = flux_queue.pop_front();
                    if (o_mass_flux !== w.mass) report_mismatch("mass", o_mass_flux, w.mass);
                    if (o_momentum_flux !== w.mom)
                        report_mismatch("momentum", o_momentum_flux, w.mom);
                    if (o_energy_flux !== w.nrg)
                        report_mismatch("energy", o_energy_flux, w.nrg);
                    if (o_fault !== w.fault)
                        report_mismatch("fault", 32'(o_fault), 32'(w.fault));
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
                i_out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 11);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Watchdog on cycles in which no beat moves on either side.
    int quiet_cycles;
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_GAMMA;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_density <= '0;
        i_momentum <= '0;
        i_energy <= '0;
        i_first_of_sweep <= 1'b0;
        gamma_m1 = longint'(GAMMA_RST);
        hdt_dx = longint'(HDX_RST);
        hdx_dt = longint'(HXD_RST);
        left_cell = '{0, 0, 0};
        have_left = 1'b0;
        mismatches = 0;
        idle_on = 1'b1;
        hold_req = 1'b0;
        stall_left = 0;
        hold_left = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_config_settings();
        test_backpressure();
        test_random();

        while (flux_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+src
src/eu1d_pkg.sv
src/eu1d_ctrl.sv
src/eu1d_dp.sv
src/euler_1d_force_flux_top.sv
sim/tb_top.sv
